@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MXQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mxq assertion failed");

// Concurrent assertion that also holds during reset.
`define MXQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mxq assertion failed");

`endif

@@ rtl/mxq_pkg.sv @@
`default_nettype none

package mxq_pkg;

    typedef enum logic [1:0] {
        MODE_INT8 = 2'd0,
        MODE_FP8  = 2'd1,
        MODE_FP4  = 2'd2,
        MODE_RSVD = 2'd3
    } mxq_mode_t;

    localparam int Fp8ExpBits  = 4;
    localparam int Fp8MantBits = 3;
    localparam int Fp8ExpBias  = 7;
    localparam int Fp4ExpBits  = 2;
    localparam int Fp4MantBits = 1;
    localparam int Fp4ExpBias  = 1;

    // Round a float32 to a small minifloat, half away from zero, saturating.
    function automatic logic [7:0] mini_quant(input logic [31:0] bits, input int eb,
                                              input int mb, input int bias);
        logic [7:0]        expo;
        logic [22:0]       frac;
        logic [23:0]       sig;
        logic signed [9:0] ef;
        logic [7:0]        sh8;
        logic [23:0]       shv;
        logic [23:0]       rbv;
        logic [8:0]        mw;
        logic [3:0]        emask;
        logic [3:0]        mmask;
        logic [7:0]        code;
        expo  = bits[30:23];
        frac  = bits[22:0];
        emask = 4'((1 << eb) - 1);
        mmask = 4'((1 << mb) - 1);
        ef    = $signed({2'b00, expo}) - 10'sd127 + 10'(bias);
        sig   = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
        code  = 8'd0;
        if (expo == 8'hFF || bits[30:0] == 31'd0) begin
            code = 8'd0;
        end else begin
            if (ef <= 10'sd0) begin
                if (expo == 8'd0) begin
                    sh8 = 8'(150 - bias - mb);
                end else begin
                    sh8 = 8'(151 - bias - mb) - expo;
                end
                if (sh8 >= 8'd32) begin
                    mw = 9'd0;
                end else begin
                    shv = sig >> sh8[4:0];
                    rbv = sig >> (sh8[4:0] - 5'd1);
                    mw  = {1'b0, shv[7:0]} + {8'd0, rbv[0]};
                    if (mw > {5'd0, mmask}) begin
                        mw = {5'd0, mmask};
                    end
                end
                ef = 10'sd0;
            end else begin
                shv = {1'b0, frac} >> (23 - mb);
                rbv = {1'b0, frac} >> (22 - mb);
                mw  = {1'b0, shv[7:0]} + {8'd0, rbv[0]};
                if (mw == 9'(1 << mb)) begin
                    mw = 9'd0;
                    ef = ef + 10'sd1;
                end
                if (ef >= $signed({6'd0, emask})) begin
                    ef = $signed({6'd0, emask});
                    mw = {5'd0, mmask};
                end
            end
            code = 8'({4'd0, ef[3:0] & emask} << mb) | {4'd0, mw[3:0] & mmask};
            if (bits[31]) begin
                code = code | 8'(1 << (eb + mb));
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mxq_if.sv @@
`default_nettype none

interface mxq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] quant_format;
    modport source (output valid, output quant_format, input ready);
    modport sink (input valid, input quant_format, output ready);
endinterface

interface mxq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink (input valid, input value_bits, output ready);
endinterface

interface mxq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code;
    modport source (output valid, output code, input ready);
    modport sink (input valid, input code, output ready);
endinterface

`default_nettype wire

@@ rtl/mx_element_quantizer.sv @@
// An accepted request passes the input register, then the result register, to the result channel.
// Throughput: one request per cycle while the result side accepts; the input register and
// the result register form a two-stage pipeline whose only loop is the valid/ready chain.
// Reset: rst_n clears both stage valid flags and sets the precision mode to int8.
`default_nettype none

module mx_element_quantizer
    import mxq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mxq_cfg_if.sink    cfg,
    mxq_in_if.sink     element,
    mxq_out_if.source  result
);

    mxq_mode_t   mode_reg;
    logic        s0_valid_reg;
    logic        s0_valid_next;
    logic [31:0] s0_bits_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_code_reg;
    logic        s1_ready;
    logic        s0_ready;
    logic [7:0]  int8_code;
    logic [7:0]  mini_code;
    logic [7:0]  code_next;

    assign cfg.ready     = 1'b1;
    assign s1_ready      = !s1_valid_reg || result.ready;
    assign s0_ready      = !s0_valid_reg || s1_ready;
    assign element.ready = s0_ready;
    assign result.valid  = s1_valid_reg;
    assign result.code   = s1_code_reg;

    mxq_int8_conv u_int8 (
        .value_bits (s0_bits_reg),
        .code       (int8_code)
    );

    mxq_mini_conv u_mini (
        .value_bits (s0_bits_reg),
        .sel_fp8    (mode_reg == MODE_FP8),
        .code       (mini_code)
    );

    always_comb
    begin
        s0_valid_next = s0_ready ? element.valid : s0_valid_reg;
        s1_valid_next = s1_ready ? s0_valid_reg : s1_valid_reg;
        code_next     = (mode_reg == MODE_INT8) ? int8_code : mini_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_INT8;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_reg <= mxq_mode_t'(cfg.quant_format);
            end
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && element.valid)
        begin
            s0_bits_reg <= element.value_bits;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_code_reg <= code_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mxq_int8_conv.sv @@
`default_nettype none

module mxq_int8_conv
    import mxq_pkg::*;
(
    input  wire logic [31:0] value_bits,
    output logic      [7:0]  code
);

    logic [7:0]  expo;
    logic [23:0] m;
    logic [30:0] q;
    logic        inc;
    logic [31:0] qr;
    logic [4:0]  sh;
    logic [32:0] half;
    logic [32:0] sum;
    logic [32:0] tw;
    logic [7:0]  t;

    assign expo = value_bits[30:23];
    assign m    = {1'b1, value_bits[22:0]};
    assign q    = {m, 7'd0} - {7'd0, m};
    assign sh   = 5'(8'd150 - expo);
    assign half = 33'd1 << (sh - 5'd1);

    always_comb
    begin
        // The product is rounded to 24 significant bits, ties to even.
        if (q[30])
        begin
            inc = q[6] && ((|q[5:0]) || q[7]);
            qr  = {1'b0, q[30:7], 7'd0} + (inc ? 32'd128 : 32'd0);
        end
        else
        begin
            inc = q[5] && ((|q[4:0]) || q[6]);
            qr  = {1'b0, q[30:6], 6'd0} + (inc ? 32'd64 : 32'd0);
        end
        sum = {1'b0, qr} + half;
        tw  = sum >> sh;
        if (value_bits[30:23] == 8'hFF && value_bits[22:0] != 23'd0)
        begin
            t = 8'd0;
        end
        else if (expo >= 8'd127)
        begin
            t = 8'd127;
        end
        else if (expo < 8'd119)
        begin
            t = 8'd0;
        end
        else if (tw > 33'd127)
        begin
            t = 8'd127;
        end
        else
        begin
            t = tw[7:0];
        end
        code = value_bits[31] ? (8'd0 - t) : t;
    end

endmodule

`default_nettype wire

@@ rtl/mxq_mini_conv.sv @@
`default_nettype none

module mxq_mini_conv
    import mxq_pkg::*;
(
    input  wire logic [31:0] value_bits,
    input  wire logic        sel_fp8,
    output logic      [7:0]  code
);

    logic [7:0] fp8_code;
    logic [7:0] fp4_code;

    assign fp8_code = mini_quant(value_bits, Fp8ExpBits, Fp8MantBits, Fp8ExpBias);
    assign fp4_code = mini_quant(value_bits, Fp4ExpBits, Fp4MantBits, Fp4ExpBias);
    assign code     = sel_fp8 ? fp8_code : fp4_code;

endmodule

`default_nettype wire

@@ rtl/mxq_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module mxq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_code
);

    // A stalled result keeps its code.
    `MXQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_code))
    // An accepted request must be followed by a valid result on the output.
    `MXQ_ASSERT(a_latency, clk, rst_n, in_valid && in_ready |-> ##2 out_valid)
    // A free result side never back-pressures the input.
    `MXQ_ASSERT(a_ready_pass, clk, rst_n, out_ready |-> in_ready)
    // No result is shown in the cycle after reset is seen asserted.
    `MXQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind mx_element_quantizer mxq_checker u_mxq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (element.valid),
    .in_ready  (element.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_code  (result.code)
);

`default_nettype wire
